// ----- hw/rtl/gbz_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbz_pkg
// Shared types, constants and helpers of the glyph bitmap zoom block.
// ----------------------------------------------------------------------------
package gbz_pkg;

	localparam int MAX_SOURCE_SIDE = 8;
	localparam int MAX_ZOOM        = 4;

	localparam int GLYPH_W   = 64;
	localparam int WORD_W    = 64;
	localparam int WNUM_W    = 4;
	localparam int SIDE_W    = 4;
	localparam int ZOOM_W    = 3;
	localparam int ZSIDE_W   = 6;   // up to MAX_SOURCE_SIDE * MAX_ZOOM
	localparam int ROW_W     = 32;  // widest zoomed row
	localparam int ACC_W     = WORD_W + ROW_W;
	localparam int FILL_W    = 7;
	localparam int BASE_W    = 6;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 4;
	localparam int OUT_TDATA_W = 72;  // zoom_word, word_number, zero fill
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH    = 4'd0,
		REG_SOURCE_HEIGHT   = 4'd1,
		REG_ZOOM_HORIZONTAL = 4'd2,
		REG_ZOOM_VERTICAL   = 4'd3
	} reg_index_t;

	// One classified glyph, ready for the back end
	typedef struct packed {
		logic [GLYPH_W-1:0] glyph;
		logic [SIDE_W-1:0]  width;
		logic [ZOOM_W-1:0]  zoom_x;
		logic [ZOOM_W-1:0]  zoom_y;
		logic [ZSIDE_W-1:0] zoom_width;
		logic [ZSIDE_W-1:0] zoom_height;
	} job_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		if (v == '0)
			return SIDE_W'(1);
		else if (v > SIDE_W'(MAX_SOURCE_SIDE))
			return SIDE_W'(MAX_SOURCE_SIDE);
		else
			return v;
	endfunction

	function automatic logic [ZOOM_W-1:0] clamp_zoom(input logic [ZOOM_W-1:0] v);
		if (v == '0)
			return ZOOM_W'(1);
		else if (v > ZOOM_W'(MAX_ZOOM))
			return ZOOM_W'(MAX_ZOOM);
		else
			return v;
	endfunction

endpackage

// ----- hw/rtl/glyph_bitmap_zoom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_bitmap_zoom
// Nearest-neighbor enlargement of a 1-bit glyph into packed 64-bit words.
// ----------------------------------------------------------------------------
// Each glyph item on the input stream yields ceil(W*Zx*H*Zy/64) words on the
// output stream, numbered from zero, the final one marked by tlast. The back
// end appends the zoomed rows (H*Zy, up to 32) one by one and emits each
// word (up to 16) once it is full or the rows are done. A two-entry queue
// lets the next glyphs be taken while one is being expanded, and the output
// register lets work go on while a finished word waits. Write the size and
// zoom registers only while idle.
module glyph_bitmap_zoom (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gbz_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gbz_pkg::CFG_DAT_W-1:0]    cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [gbz_pkg::GLYPH_W-1:0]      s_axis_tdata,   // [63:0] glyph_bits
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [63:0] zoom_word, [67:64] word_number, [71:68] zero
	output logic [gbz_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tlast
);
	import gbz_pkg::*;

	logic                push;
	job_t                push_job;
	logic                queue_full;
	logic                pop;
	logic                queue_empty;
	job_t                head_job;
	logic [WORD_W-1:0]   out_word;
	logic [WNUM_W-1:0]   out_number;

	gbz_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_glyph   (s_axis_tdata),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	gbz_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.empty    (queue_empty),
		.head_job (head_job)
	);

	gbz_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (queue_empty),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_word   (out_word),
		.out_number (out_number),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - WORD_W - WNUM_W){1'b0}}, out_number, out_word};

endmodule

// ----- hw/rtl/gbz_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbz_front
// Configuration registers and input side: clamps the sizes and hands each
// accepted glyph to the queue as a job.
// ----------------------------------------------------------------------------
module gbz_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gbz_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gbz_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [gbz_pkg::GLYPH_W-1:0]    in_glyph,
	input  logic                           queue_full,
	output logic                           push,
	output gbz_pkg::job_t                  push_job
);
	import gbz_pkg::*;

	logic [SIDE_W-1:0] width_q;
	logic [SIDE_W-1:0] height_q;
	logic [ZOOM_W-1:0] zoom_x_q;
	logic [ZOOM_W-1:0] zoom_y_q;
	logic [SIDE_W-1:0] w_c;
	logic [SIDE_W-1:0] h_c;
	logic [ZOOM_W-1:0] zx_c;
	logic [ZOOM_W-1:0] zy_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_W'(5);
			height_q <= SIDE_W'(7);
			zoom_x_q <= ZOOM_W'(1);
			zoom_y_q <= ZOOM_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SOURCE_WIDTH:    width_q  <= cfg_data[SIDE_W-1:0];
				REG_SOURCE_HEIGHT:   height_q <= cfg_data[SIDE_W-1:0];
				REG_ZOOM_HORIZONTAL: zoom_x_q <= cfg_data[ZOOM_W-1:0];
				REG_ZOOM_VERTICAL:   zoom_y_q <= cfg_data[ZOOM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_c  = clamp_side(width_q);
		h_c  = clamp_side(height_q);
		zx_c = clamp_zoom(zoom_x_q);
		zy_c = clamp_zoom(zoom_y_q);
		push_job.glyph       = in_glyph;
		push_job.width       = w_c;
		push_job.zoom_x      = zx_c;
		push_job.zoom_y      = zy_c;
		push_job.zoom_width  = ZSIDE_W'({2'b00, w_c} * {3'b000, zx_c});
		push_job.zoom_height = ZSIDE_W'({2'b00, h_c} * {3'b000, zy_c});
	end

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

endmodule

// ----- hw/rtl/gbz_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbz_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module gbz_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gbz_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output gbz_pkg::job_t head_job
);
	import gbz_pkg::*;

	job_t       entry_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'(QUEUE_DEPTH));
	assign empty    = (count_q == 2'd0);
	assign head_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/gbz_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbz_back
// Zoom engine: expands each source row zoom_y times, one zoomed row per cycle
// while no word is due, packs the rows into a bit accumulator and emits 64-bit
// words through an output register.
// ----------------------------------------------------------------------------
module gbz_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        empty,
	input  gbz_pkg::job_t               head_job,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gbz_pkg::WORD_W-1:0]  out_word,
	output logic [gbz_pkg::WNUM_W-1:0]  out_number,
	output logic                        out_last
);
	import gbz_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t              state_q;
	logic [GLYPH_W-1:0]  glyph_q;
	logic [SIDE_W-1:0]   width_q;
	logic [ZOOM_W-1:0]   zoom_x_q;
	logic [ZOOM_W-1:0]   zoom_y_q;
	logic [ZSIDE_W-1:0]  zoom_width_q;
	logic [ZSIDE_W-1:0]  rows_left_q;
	logic [1:0]          sub_q;
	logic [BASE_W-1:0]   base_q;
	logic [ACC_W-1:0]    acc_q;
	logic [FILL_W-1:0]   fill_q;
	logic [WNUM_W-1:0]   wnum_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   out_word_q;
	logic [WNUM_W-1:0]   out_number_q;
	logic                out_last_q;

	logic [GLYPH_W-1:0]  shifted;
	logic [7:0]          src_row;
	logic [8:0]          width_mask;
	logic [ROW_W-1:0]    zoom_row;
	logic                rows_done;
	logic                emit;
	logic                emit_last;
	logic                out_free;
	logic                load_word;

	// Replicate each source pixel zoom_x times along the row
	function automatic logic [ROW_W-1:0] expand_row(input logic [7:0] row,
			input logic [ZOOM_W-1:0] zx);
		logic [ROW_W-1:0] r32;
		logic [ROW_W-1:0] e;
		r32 = {24'd0, row};
		e   = '0;
		for (int c = 0; c < ROW_W; c++) begin
			case (zx)
				3'd2:    e[c] = r32[c / 2];
				3'd3:    e[c] = r32[c / 3];
				3'd4:    e[c] = r32[c / 4];
				default: e[c] = r32[c];
			endcase
		end
		return e;
	endfunction

	always_comb begin
		shifted    = glyph_q >> base_q;
		width_mask = (9'd1 << width_q) - 9'd1;
		src_row    = shifted[7:0] & width_mask[7:0];
		zoom_row   = expand_row(src_row, zoom_x_q);
		rows_done  = (rows_left_q == '0);
		emit       = fill_q[6] || (rows_done && (fill_q != '0));
		emit_last  = rows_done && (fill_q <= FILL_W'(WORD_W));
		out_free   = !out_valid_q || out_ready;
		load_word  = (state_q == ST_RUN) && emit && out_free;
	end

	assign pop        = (state_q == ST_IDLE) && !empty;
	assign out_valid  = out_valid_q;
	assign out_word   = out_word_q;
	assign out_number = out_number_q;
	assign out_last   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			glyph_q      <= '0;
			width_q      <= '0;
			zoom_x_q     <= '0;
			zoom_y_q     <= '0;
			zoom_width_q <= '0;
			rows_left_q  <= '0;
			sub_q        <= '0;
			base_q       <= '0;
			acc_q        <= '0;
			fill_q       <= '0;
			wnum_q       <= '0;
			out_valid_q  <= 1'b0;
			out_word_q   <= '0;
			out_number_q <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (load_word)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						glyph_q      <= head_job.glyph;
						width_q      <= head_job.width;
						zoom_x_q     <= head_job.zoom_x;
						zoom_y_q     <= head_job.zoom_y;
						zoom_width_q <= head_job.zoom_width;
						rows_left_q  <= head_job.zoom_height;
						sub_q        <= '0;
						base_q       <= '0;
						acc_q        <= '0;
						fill_q       <= '0;
						wnum_q       <= '0;
						state_q      <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (emit) begin
						if (out_free) begin
							out_word_q   <= acc_q[WORD_W-1:0];
							out_number_q <= wnum_q;
							out_last_q   <= emit_last;
							acc_q        <= {{WORD_W{1'b0}}, acc_q[ACC_W-1:WORD_W]};
							fill_q       <= fill_q[6] ? {1'b0, fill_q[5:0]} : '0;
							wnum_q       <= wnum_q + WNUM_W'(1);
							if (emit_last)
								state_q <= ST_IDLE;
						end
					end else begin
						// append one zoomed row at the fill point
						acc_q       <= acc_q | ({{WORD_W{1'b0}}, zoom_row} << fill_q);
						fill_q      <= fill_q + FILL_W'(zoom_width_q);
						rows_left_q <= rows_left_q - ZSIDE_W'(1);
						if (sub_q == 2'(zoom_y_q - ZOOM_W'(1))) begin
							sub_q  <= '0;
							base_q <= base_q + BASE_W'(width_q);
						end else begin
							sub_q <= sub_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/gbz_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbz_checker
// Port-level checks of the glyph bitmap zoom output stream.
// ----------------------------------------------------------------------------
module gbz_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [gbz_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input  logic                             m_axis_tlast
);
	import gbz_pkg::*;

	logic                out_take;
	logic [WNUM_W-1:0]   wnum;

	assign out_take = m_axis_tvalid && m_axis_tready;
	assign wnum     = m_axis_tdata[WORD_W +: WNUM_W];

	// hold a stalled item
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("stalled output item changed");

	// word numbers advance by one within a glyph
	a_wnum_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !m_axis_tlast |=> !m_axis_tvalid
			|| (wnum == WNUM_W'($past(wnum) + WNUM_W'(1))))
		else $error("word number skipped");

	// a new glyph starts at word zero
	a_wnum_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && m_axis_tlast |=> !m_axis_tvalid || (wnum == '0))
		else $error("glyph did not restart at word zero");

	// sixteen words at most per glyph
	a_wnum_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (wnum == WNUM_W'(15)) |-> m_axis_tlast)
		else $error("glyph runs past sixteen words");

endmodule

bind glyph_bitmap_zoom gbz_checker u_gbz_checker (.*);

// ----- tb/tb_glyph_bitmap_zoom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_bitmap_zoom
// Self-checking bench for the nearest-neighbor glyph enlarger.
// ----------------------------------------------------------------------------
// Programs glyph size and zoom factors over the register channel, streams
// glyphs in and checks each output word, its number and its end flag against
// a behavioral expansion of the glyph. Directed tests cover the size and zoom
// extremes, out-of-range register values, unused glyph bits and writes to
// unknown register indexes. Random phases follow with random geometry and
// random gaps on both streams in most phases.
// ----------------------------------------------------------------------------
module tb_glyph_bitmap_zoom;
	import gbz_pkg::*;

	localparam int WORD_CAP       = 16;
	localparam int NUM_REGS       = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 64;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 60;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [WNUM_W-1:0] number;
		logic              last;
	} zoom_word_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DAT_W-1:0]   cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [GLYPH_W-1:0]     s_axis_tdata;   // [63:0] glyph_bits
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [63:0] zoom_word, [67:64] word_number, [71:68] 0
	logic                   m_axis_tlast;

	// Bench copy of the geometry registers
	logic [SIDE_W-1:0] geo_width;
	logic [SIDE_W-1:0] geo_height;
	logic [ZOOM_W-1:0] geo_zoom_x;
	logic [ZOOM_W-1:0] geo_zoom_y;

	zoom_word_t pending_words[$];
	zoom_word_t head_word;
	int         mismatches;
	int         quiet_cycles;
	int         stall_left;
	bit         tx_gaps_on;
	bit         rx_stalls_on;

	glyph_bitmap_zoom i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Replicate each source pixel into a Zx by Zy block and queue the packed words
	task automatic expand_glyph(input logic [GLYPH_W-1:0] glyph);
		logic [WORD_W-1:0] words [WORD_CAP];
		zoom_word_t        item;
		int                w, h, zx, zy, zw, zh, count, src, pos;
		w  = (geo_width == 0) ? 1 :
			(geo_width > MAX_SOURCE_SIDE) ? MAX_SOURCE_SIDE : int'(geo_width);
		h  = (geo_height == 0) ? 1 :
			(geo_height > MAX_SOURCE_SIDE) ? MAX_SOURCE_SIDE : int'(geo_height);
		zx = (geo_zoom_x == 0) ? 1 : (geo_zoom_x > MAX_ZOOM) ? MAX_ZOOM : int'(geo_zoom_x);
		zy = (geo_zoom_y == 0) ? 1 : (geo_zoom_y > MAX_ZOOM) ? MAX_ZOOM : int'(geo_zoom_y);
		zw = w * zx;
		zh = h * zy;
		count = (zw * zh + 63) / 64;
		if (count > WORD_CAP)
			count = WORD_CAP;
		for (int k = 0; k < WORD_CAP; k++)
			words[k] = '0;
		for (int row = 0; row < zh; row++) begin
			for (int col = 0; col < zw; col++) begin
				src = (row / zy) * w + (col / zx);
				pos = row * zw + col;
				if ((pos >> 6) < WORD_CAP && src < GLYPH_W && glyph[src])
					words[pos >> 6][pos & 63] = 1'b1;
			end
		end
		for (int k = 0; k < count; k++) begin
			item.word   = words[k];
			item.number = WNUM_W'(k);
			item.last   = (k == count - 1);
			pending_words.push_back(item);
		end
	endtask

	// Leaves cfg_valid high; end_writes drops it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SOURCE_WIDTH:    geo_width  = data;
			REG_SOURCE_HEIGHT:   geo_height = data;
			REG_ZOOM_HORIZONTAL: geo_zoom_x = data[ZOOM_W-1:0];
			REG_ZOOM_VERTICAL:   geo_zoom_y = data[ZOOM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_valid <= 1'b0;
	endtask

	task automatic set_geometry(input logic [CFG_DAT_W-1:0] w, input logic [CFG_DAT_W-1:0] h,
			input logic [CFG_DAT_W-1:0] zx, input logic [CFG_DAT_W-1:0] zy);
		write_reg(REG_SOURCE_WIDTH, w);
		write_reg(REG_SOURCE_HEIGHT, h);
		write_reg(REG_ZOOM_HORIZONTAL, zx);
		write_reg(REG_ZOOM_VERTICAL, zy);
		end_writes();
	endtask

	// Leaves tvalid high so the next item can follow without a bubble
	task automatic send_glyph(input logic [GLYPH_W-1:0] glyph);
		int gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= glyph;
		do @(posedge clk); while (!s_axis_tready);
		expand_glyph(glyph);
	endtask

	// Hold off the sender until every queued word has come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
	endtask

	function automatic logic [GLYPH_W-1:0] random_glyph();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_reset_values();
		send_glyph('1);
		send_glyph('0);
		send_glyph(random_glyph());
	endtask

	task automatic test_size_extremes();
		wait_drained();
		set_geometry(1, 1, 1, 1);
		send_glyph(64'h1);
		send_glyph('1);
		wait_drained();
		set_geometry(8, 8, 4, 4);
		send_glyph('1);
		send_glyph(random_glyph());
		wait_drained();
		set_geometry(8, 8, 1, 1);
		send_glyph(random_glyph());
		wait_drained();
		set_geometry(8, 1, 4, 1);
		send_glyph(random_glyph());
		wait_drained();
		set_geometry(1, 8, 1, 4);
		send_glyph(random_glyph());
	endtask

	// Zero sizes act as one, oversize values saturate, zoom keeps only three bits
	task automatic test_register_clamps();
		wait_drained();
		set_geometry(0, 0, 0, 0);
		send_glyph('1);
		wait_drained();
		set_geometry(15, 15, 7, 7);
		send_glyph(random_glyph());
		wait_drained();
		set_geometry(9, 12, 15, 8);
		send_glyph(random_glyph());
	endtask

	task automatic test_unused_bits();
		wait_drained();
		set_geometry(3, 3, 2, 3);
		send_glyph(~64'h1ff);
		send_glyph('1);
	endtask

	task automatic test_unknown_index();
		wait_drained();
		write_reg(REG_SOURCE_WIDTH, 2);
		write_reg(REG_SOURCE_HEIGHT, 3);
		write_reg(REG_ZOOM_HORIZONTAL, 3);
		write_reg(REG_ZOOM_VERTICAL, 2);
		for (int i = NUM_REGS; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), CFG_DAT_W'($urandom_range(0, 15)));
		end_writes();
		send_glyph('1);
		send_glyph(random_glyph());
	endtask

	task automatic test_random();
		int r;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			tx_gaps_on   = !(p == 0 || p == 2);
			rx_stalls_on = !(p == 0 || p == 3);
			set_geometry(CFG_DAT_W'($urandom_range(0, 15)), CFG_DAT_W'($urandom_range(0, 15)),
				CFG_DAT_W'($urandom_range(0, 15)), CFG_DAT_W'($urandom_range(0, 15)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ((p == 4 && n == PHASE_ITEMS / 2) || $urandom_range(0, 39) == 0)
					wait_drained();
				r = $urandom_range(0, 99);
				if (r < 85)
					send_glyph(random_glyph());
				else if (r < 90)
					send_glyph('1);
				else if (r < 95)
					send_glyph('0);
				else
					send_glyph(GLYPH_W'(1) << $urandom_range(0, GLYPH_W - 1));
			end
		end
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	// Receiver back-pressure: runs of stalls, mostly short
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (rx_stalls_on)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word exp none got %h", $time, m_axis_tdata);
				mismatches++;
			end else begin
				head_word = pending_words.pop_front();
				if (m_axis_tdata[WORD_W-1:0] !== head_word.word) begin
					$display("%0t: zoom_word exp %h got %h", $time, head_word.word,
						m_axis_tdata[WORD_W-1:0]);
					mismatches++;
				end
				if (m_axis_tdata[WORD_W+WNUM_W-1:WORD_W] !== head_word.number) begin
					$display("%0t: word_number exp %0d got %0d", $time, head_word.number,
						m_axis_tdata[WORD_W+WNUM_W-1:WORD_W]);
					mismatches++;
				end
				if (m_axis_tdata[OUT_TDATA_W-1:WORD_W+WNUM_W] !== '0) begin
					$display("%0t: tdata fill exp 0 got %h", $time,
						m_axis_tdata[OUT_TDATA_W-1:WORD_W+WNUM_W]);
					mismatches++;
				end
				if (m_axis_tlast !== head_word.last) begin
					$display("%0t: last_word exp %0b got %0b", $time, head_word.last,
						m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	// Abort when no channel moves an item for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		stall_left    = 0;
		quiet_cycles  = 0;
		mismatches    = 0;
		tx_gaps_on    = 1'b1;
		rx_stalls_on  = 1'b1;
		geo_width     = 4'd5;
		geo_height    = 4'd7;
		geo_zoom_x    = 3'd1;
		geo_zoom_y    = 3'd1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_size_extremes();
		test_register_clamps();
		test_unused_bits();
		test_unknown_index();
		test_random();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/gbz_pkg.sv
hw/rtl/gbz_front.sv
hw/rtl/gbz_queue.sv
hw/rtl/gbz_back.sv
hw/rtl/glyph_bitmap_zoom.sv
hw/rtl/gbz_checker.sv
tb/tb_glyph_bitmap_zoom.sv
